### rtl/dhcp_reply_option_parser_assert.svh
// assertion macros for the dhcp reply option parser checker
`ifndef DHCP_REPLY_OPTION_PARSER_ASSERT_SVH
`define DHCP_REPLY_OPTION_PARSER_ASSERT_SVH

// same-cycle implication, off during reset
`define DRO_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dhcp reply option parser check failed");

// next-cycle implication, off during reset
`define DRO_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dhcp reply option parser check failed");

`endif

### rtl/dhcp_rop_pkg.sv
// shared types and constants for the dhcp reply option parser
`default_nettype none

package dhcp_rop_pkg;

   localparam int MaxLen     = 512;
   localparam int CountWidth = $clog2(MaxLen + 1);

   localparam int AddrFirst  = 16;
   localparam int AddrLast   = 19;
   localparam int OptStart   = 240;

   localparam logic [7:0] OptPad      = 8'h00;
   localparam logic [7:0] OptEnd      = 8'hFF;
   localparam logic [7:0] OptMsgType  = 8'd53;
   localparam logic [7:0] OptServerId = 8'd54;
   localparam logic [7:0] MsgAck      = 8'd5;
   localparam logic [7:0] LenMsgType  = 8'd1;
   localparam logic [7:0] LenServerId = 8'd4;

   typedef enum logic [1:0] {
      PH_CODE,
      PH_LEN,
      PH_DATA,
      PH_STOP
   } phase_type;

   typedef struct packed {
      logic        too_short;
      logic [31:0] offered_addr;
      logic [7:0]  message_type;
      logic        ack_seen;
      logic [31:0] server_id;
   } result_type;

endpackage

`default_nettype wire

### rtl/dhcp_rop_parser.sv
// option walker: per-reply state, option decoding and result formation
`default_nettype none

module dhcp_rop_parser
   import dhcp_rop_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       take,
   input  wire logic [7:0] payload_byte,
   input  wire logic       last_byte,
   output result_type      result,
   output logic            result_valid
);

   logic [CountWidth-1:0] count_ff, count_in;
   phase_type             phase_ff, phase_in;
   logic [7:0]            code_ff, code_in;
   logic [7:0]            left_ff, left_in;
   logic [7:0]            length_ff, length_in;
   logic [31:0]           addr_ff, addr_in;
   logic [31:0]           srv_pend_ff, srv_pend_in;
   logic [31:0]           srv_kept_ff, srv_kept_in;
   logic [7:0]            type_pend_ff, type_pend_in;
   logic [7:0]            type_kept_ff, type_kept_in;
   logic                  ack_ff, ack_in;

   logic                  active;
   logic                  commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         phase_ff     <= PH_CODE;
         code_ff      <= '0;
         left_ff      <= '0;
         length_ff    <= '0;
         addr_ff      <= '0;
         srv_pend_ff  <= '0;
         srv_kept_ff  <= '0;
         type_pend_ff <= '0;
         type_kept_ff <= '0;
         ack_ff       <= 1'b0;
      end else begin
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         code_ff      <= code_in;
         left_ff      <= left_in;
         length_ff    <= length_in;
         addr_ff      <= addr_in;
         srv_pend_ff  <= srv_pend_in;
         srv_kept_ff  <= srv_kept_in;
         type_pend_ff <= type_pend_in;
         type_kept_ff <= type_kept_in;
         ack_ff       <= ack_in;
      end
   end

   always_comb begin
      count_in     = count_ff;
      phase_in     = phase_ff;
      code_in      = code_ff;
      left_in      = left_ff;
      length_in    = length_ff;
      addr_in      = addr_ff;
      srv_pend_in  = srv_pend_ff;
      srv_kept_in  = srv_kept_ff;
      type_pend_in = type_pend_ff;
      type_kept_in = type_kept_ff;
      ack_in       = ack_ff;
      commit       = 1'b0;
      active       = count_ff < CountWidth'(MaxLen);

      if (take && active) begin
         if (count_ff >= CountWidth'(AddrFirst) && count_ff <= CountWidth'(AddrLast)) begin
            addr_in = {addr_ff[23:0], payload_byte};
         end
         if (count_ff >= CountWidth'(OptStart)) begin
            unique case (phase_ff)
               PH_CODE: begin
                  if (payload_byte == OptEnd) begin
                     phase_in = PH_STOP;
                  end else if (payload_byte != OptPad) begin
                     code_in  = payload_byte;
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  length_in    = payload_byte;
                  left_in      = payload_byte;
                  srv_pend_in  = '0;
                  type_pend_in = '0;
                  // zero length completes at once and cannot match either option
                  phase_in     = (payload_byte == 8'd0) ? PH_CODE : PH_DATA;
               end
               PH_DATA: begin
                  if (left_ff == length_ff) begin
                     type_pend_in = payload_byte;
                  end
                  srv_pend_in = {srv_pend_ff[23:0], payload_byte};
                  left_in     = left_ff - 8'd1;
                  if (left_ff == 8'd1) begin
                     commit   = 1'b1;
                     phase_in = PH_CODE;
                  end
               end
               PH_STOP: begin
               end
               default: begin
               end
            endcase
         end
         count_in = count_ff + CountWidth'(1);
      end

      if (commit) begin
         if (code_ff == OptMsgType && length_ff == LenMsgType) begin
            type_kept_in = type_pend_in;
            if (type_pend_in == MsgAck) begin
               ack_in = 1'b1;
            end
         end
         if (code_ff == OptServerId && length_ff == LenServerId) begin
            srv_kept_in = srv_pend_in;
         end
      end

      result_valid = take && last_byte;
      if (count_in < CountWidth'(OptStart)) begin
         result = '{too_short: 1'b1, offered_addr: '0, message_type: '0,
                    ack_seen: 1'b0, server_id: '0};
      end else begin
         result = '{too_short: 1'b0, offered_addr: addr_in, message_type: type_kept_in,
                    ack_seen: ack_in, server_id: srv_kept_in};
      end

      // end of reply: back to the idle state for the next one
      if (result_valid) begin
         count_in     = '0;
         phase_in     = PH_CODE;
         code_in      = '0;
         left_in      = '0;
         length_in    = '0;
         addr_in      = '0;
         srv_pend_in  = '0;
         srv_kept_in  = '0;
         type_pend_in = '0;
         type_kept_in = '0;
         ack_in       = 1'b0;
      end
   end

endmodule

`default_nettype wire

### rtl/dhcp_reply_option_parser.sv
// top level: input register, option walker and result register
//
// takes a dhcp reply payload one byte per item, with the final byte marked, and
// gives one result item per reply: the offered address from bytes 16 to 19, the
// last message type and server identifier options found from byte 240 on, an
// ack flag, and a too-short flag for replies under 240 bytes (other fields then
// zero). bytes past the first 512 are ignored. a byte is taken every clock unless the
// input is stalled; the input register feeds the option walker, whose state updates in
// a single pass, and the result lands in the output register once the final byte
// leaves the input register. the result register frees the input side, so a stall on
// the result channel only holds the input when another final byte arrives.
`default_nettype none

module dhcp_reply_option_parser
   import dhcp_rop_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_payload_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_too_short,
   output logic [31:0]      rsp_offered_addr,
   output logic [7:0]       rsp_message_type,
   output logic             rsp_ack_seen,
   output logic [31:0]      rsp_server_id
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       accept;
   logic       advance;

   result_type result;
   logic       result_valid;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   // a non-final byte never needs the result register
   assign advance   = in_valid_ff && (!in_last_ff || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_payload_byte;
         in_last_ff <= req_last_byte;
      end
   end

   dhcp_rop_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .take         (advance),
      .payload_byte (in_byte_ff),
      .last_byte    (in_last_ff),
      .result       (result),
      .result_valid (result_valid)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (result_valid) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_valid) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_too_short    = out_ff.too_short;
   assign rsp_offered_addr = out_ff.offered_addr;
   assign rsp_message_type = out_ff.message_type;
   assign rsp_ack_seen     = out_ff.ack_seen;
   assign rsp_server_id    = out_ff.server_id;

endmodule

`default_nettype wire

### rtl/dhcp_rop_checker.sv
// port-level checks for the dhcp reply option parser, bound to the top level
`default_nettype none

`include "dhcp_reply_option_parser_assert.svh"

module dhcp_rop_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [7:0]  req_payload_byte,
   input wire logic        req_last_byte,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_too_short,
   input wire logic [31:0] rsp_offered_addr,
   input wire logic [7:0]  rsp_message_type,
   input wire logic        rsp_ack_seen,
   input wire logic [31:0] rsp_server_id
);

   logic [80:0] rsp_bundle;
   logic        req_seen;

   assign rsp_bundle = {rsp_too_short, rsp_offered_addr, rsp_message_type,
                        rsp_ack_seen, rsp_server_id};
   assign req_seen   = req_valid || req_stall || (req_payload_byte != 8'd0) || req_last_byte;

   // stalled result item holds
   `DRO_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_bundle))

   // short reply reports nothing else
   `DRO_ASSERT_NOW(a_short_zero, rsp_valid && rsp_too_short, (rsp_offered_addr == 32'd0) && (rsp_message_type == 8'd0) && !rsp_ack_seen && (rsp_server_id == 32'd0))

   // a kept ack message type always raises the ack flag
   `DRO_ASSERT_NOW(a_ack_flag, rsp_valid && !rsp_too_short && (rsp_message_type == 8'd5), rsp_ack_seen)

   // no result item straight out of reset
   `DRO_ASSERT_NOW(a_reset_quiet, $past(reset) || !req_seen && $past(reset), !rsp_valid)

endmodule

bind dhcp_reply_option_parser dhcp_rop_checker u_checker (.*);

`default_nettype wire

### tb/tb.sv
// testbench for the dhcp reply option parser: directed and random replies checked against a predictor
`timescale 1ns / 1ps

module tb
   import dhcp_rop_pkg::*;
;

   localparam int QuietLimit      = 3000;
   localparam int HoldCycles      = 300;
   localparam int RepliesPerPhase = 4;
   localparam int HoldReplies     = 12;
   localparam int CaseCount       = 4;

   typedef struct packed {
      logic [10:0]  len;
      logic [9:0]   opt_at;
      logic [31:0]  addr;
      logic [191:0] opts;
      logic [4:0]   n_opts;
      logic         typed;
      result_type   want;
   } reply_case_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_payload_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_too_short;
   logic [31:0] rsp_offered_addr;
   logic [7:0]  rsp_message_type;
   logic        rsp_ack_seen;
   logic [31:0] rsp_server_id;

   // predictor state, per reply
   int unsigned seen_count = 0;
   phase_type   walk_phase = PH_CODE;
   logic [7:0]  opt_code = '0;
   logic [7:0]  opt_len = '0;
   logic [7:0]  opt_remain = '0;
   logic [31:0] addr_acc = '0;
   logic [31:0] srv_acc = '0;
   logic [31:0] srv_kept = '0;
   logic [7:0]  type_acc = '0;
   logic [7:0]  type_kept = '0;
   logic        ack_hit = 1'b0;

   result_type  awaited_replies[$];
   logic [7:0]  reply_bytes[$];
   logic        case_typed = 1'b0;
   result_type  case_expect = '0;
   int          mismatch_count = 0;
   int          quiet_cycles = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_request = 0;
   int          sender_plan[4] = '{0, 55, 0, 12};
   int          stall_plan[4] = '{0, 0, 55, 12};

   reply_case_type dir_cases[CaseCount] = '{
      '{11'd1, 10'd240, 32'h0, 192'h0, 5'd0, 1'b1, '{1'b1, 32'h0, 8'h00, 1'b0, 32'h0}},
      '{11'd239, 10'd240, 32'hDEADBEEF, 192'h0, 5'd0, 1'b1,
        '{1'b1, 32'h0, 8'h00, 1'b0, 32'h0}},
      '{11'd263, 10'd240, 32'hC0A80164,
        {8'd53, 8'd1, 8'd5, 8'd54, 8'd4, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'd53, 8'd2, 8'd5,
         8'd5, 8'd55, 8'd1, 8'd9, 8'd53, 8'd1, 8'd3, 8'hFF, 8'd53, 8'd1, 8'd7},
        5'd23, 1'b0, '0},
      '{11'd514, 10'd501, 32'hA5A5A5A5,
        {8'd0, 8'd53, 8'd0, 8'd53, 8'd1, 8'd5, 8'd54, 8'd4, 8'hDE, 8'hAD, 8'hBE},
        5'd11, 1'b0, '0}
   };

   dhcp_reply_option_parser uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_too_short    (rsp_too_short),
      .rsp_offered_addr (rsp_offered_addr),
      .rsp_message_type (rsp_message_type),
      .rsp_ack_seen     (rsp_ack_seen),
      .rsp_server_id    (rsp_server_id)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void settle_option();
      if (opt_code == OptMsgType && opt_len == LenMsgType) begin
         type_kept = type_acc;
         if (type_acc == MsgAck) ack_hit = 1'b1;
      end
      if (opt_code == OptServerId && opt_len == LenServerId) srv_kept = srv_acc;
   endfunction

   function automatic void walk_option_byte(logic [7:0] b);
      case (walk_phase)
         PH_CODE: begin
            if (b == OptEnd) begin
               walk_phase = PH_STOP;
            end else if (b != OptPad) begin
               opt_code = b;
               walk_phase = PH_LEN;
            end
         end
         PH_LEN: begin
            opt_len = b;
            opt_remain = b;
            srv_acc = '0;
            type_acc = '0;
            if (b == 8'd0) begin
               settle_option();
               walk_phase = PH_CODE;
            end else begin
               walk_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            if (opt_remain == opt_len) type_acc = b;
            srv_acc = {srv_acc[23:0], b};
            opt_remain = opt_remain - 8'd1;
            if (opt_remain == 8'd0) begin
               settle_option();
               walk_phase = PH_CODE;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void walk_reply_byte(logic [7:0] b, logic last);
      result_type r;
      if (seen_count < MaxLen) begin
         if (seen_count >= AddrFirst && seen_count <= AddrLast) addr_acc = {addr_acc[23:0], b};
         if (seen_count >= OptStart) walk_option_byte(b);
         seen_count++;
      end
      if (last) begin
         r = '0;
         if (seen_count < OptStart) begin
            r.too_short = 1'b1;
         end else begin
            r.offered_addr = addr_acc;
            r.message_type = type_kept;
            r.ack_seen = ack_hit;
            r.server_id = srv_kept;
         end
         awaited_replies.push_back(case_typed ? case_expect : r);
         seen_count = 0;
         walk_phase = PH_CODE;
         opt_code = '0;
         opt_len = '0;
         opt_remain = '0;
         addr_acc = '0;
         srv_acc = '0;
         srv_kept = '0;
         type_acc = '0;
         type_kept = '0;
         ack_hit = 1'b0;
      end
   endfunction

   task automatic send_reply();
      int i;
      for (i = 0; i < reply_bytes.size(); i++) begin
         req_valid <= 1'b1;
         req_payload_byte <= reply_bytes[i];
         req_last_byte <= (i == reply_bytes.size() - 1);
         do @(posedge clock); while (req_stall);
         walk_reply_byte(reply_bytes[i], i == reply_bytes.size() - 1);
         if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   task automatic make_random_reply(input int max_len);
      int target;
      reply_bytes.delete();
      case_typed = 1'b0;
      target = $urandom_range(1, max_len);
      repeat (target) reply_bytes.push_back(8'($urandom));
   endtask

   always @(posedge clock) begin : receiver
      int hold_served;
      int hold_count;
      if (hold_served != hold_request) begin
         hold_served = hold_request;
         hold_count = HoldCycles;
      end
      if (hold_count > 0) begin
         hold_count--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin : check_replies
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result item: short=%0b addr=%h type=%h ack=%0b srv=%h",
                        rsp_too_short, rsp_offered_addr, rsp_message_type, rsp_ack_seen,
                        rsp_server_id);
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_too_short !== want.too_short || rsp_offered_addr !== want.offered_addr ||
                rsp_message_type !== want.message_type || rsp_ack_seen !== want.ack_seen ||
                rsp_server_id !== want.server_id) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected short=%0b addr=%h type=%h ack=%0b srv=%h",
                           want.too_short, want.offered_addr, want.message_type,
                           want.ack_seen, want.server_id);
                  $display("          actual   short=%0b addr=%h type=%h ack=%0b srv=%h",
                           rsp_too_short, rsp_offered_addr, rsp_message_type, rsp_ack_seen,
                           rsp_server_id);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int k, i, j, n;
      logic [7:0] b;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < CaseCount; k++) begin
         reply_bytes.delete();
         n = dir_cases[k].n_opts;
         for (i = 0; i < dir_cases[k].len; i++) begin
            j = i - int'(dir_cases[k].opt_at);
            if (i >= AddrFirst && i <= AddrLast) b = dir_cases[k].addr[8 * (AddrLast - i) +: 8];
            else if (i < OptStart) b = 8'(i) ^ 8'hA5;
            else if (j >= 0 && j < n) b = dir_cases[k].opts[8 * (n - 1 - j) +: 8];
            else b = OptPad;
            reply_bytes.push_back(b);
         end
         case_typed = dir_cases[k].typed;
         case_expect = dir_cases[k].want;
         send_reply();
      end
      drain_replies();

      // output held off while short replies keep coming
      hold_request <= hold_request + 1;
      repeat (HoldReplies) begin
         make_random_reply(3);
         send_reply();
      end
      drain_replies();

      for (k = 0; k < 4; k++) begin
         send_idle_pct = sender_plan[k];
         stall_pct = stall_plan[k];
         repeat (RepliesPerPhase) begin
            make_random_reply(8);
            send_reply();
         end
         drain_replies();
      end

      stall_pct = 0;
      repeat (8) @(posedge clock);
      mismatch_count += awaited_replies.size();
      if (mismatch_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
